// ===== hw/rtl/speculation_depth_controller_unit_macros.svh =====
// Assertion helpers used by the checker file sdcu_checker.sv.
`ifndef SPECULATION_DEPTH_CONTROLLER_UNIT_MACROS_SVH
`define SPECULATION_DEPTH_CONTROLLER_UNIT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define SDCU_ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define SDCU_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sdcu_pkg.sv =====
`timescale 1ns / 1ps

package sdcu_pkg;

	typedef enum logic {
		OP_START   = 1'b0,
		OP_OBSERVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK          = 2'd0,
		ERR_ACC_GT_PROP = 2'd1,
		ERR_BAD_DEPTH   = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		CFG_MAX_DEPTH     = 2'd0,
		CFG_PROMPT_LENGTH = 2'd1,
		CFG_DEMOTION_ON   = 2'd2,
		CFG_EARLY_DEM_ON  = 2'd3
	} cfg_idx_t;

	localparam logic [19:0] PROMPT_SHORT_MAX         = 20'd2048;
	localparam logic [3:0]  PROBE_ROUNDS             = 4'd8;
	localparam logic [3:0]  MONITOR_ROUNDS           = 4'd12;
	localparam logic [3:0]  PROBATION_ROUNDS         = 4'd4;
	localparam logic [7:0]  PROBE_ACCEPT_NEEDED      = 8'd10;
	localparam logic [1:0]  LOSING_WINDOWS_TO_DEMOTE = 2'd2;

	localparam logic [2:0] DEPTH_IDLE    = 3'd0;
	localparam logic [2:0] DEPTH_BAD_ONE = 3'd1;
	localparam logic [2:0] DEPTH_REDUCED = 3'd2;
	localparam logic [2:0] DEPTH_PROBED  = 3'd3;
	localparam logic [2:0] DEPTH_MAX_OK  = 3'd4;

	localparam logic [2:0]  RST_MAX_DEPTH     = 3'd3;
	localparam logic [19:0] RST_PROMPT_LENGTH = 20'd0;
	localparam logic        RST_DEMOTION_ON   = 1'b1;
	localparam logic        RST_EARLY_DEM_ON  = 1'b0;

	typedef struct packed {
		logic [2:0]  max_depth;
		logic [19:0] prompt_length;
		logic        demotion_on;
		logic        early_demotion_on;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  cur_depth;
		logic        probing;
		logic        monitoring;
		logic [3:0]  probe_round_count;
		logic [7:0]  probe_accept_sum;
		logic [3:0]  window_round_count;
		logic [7:0]  window_proposed_sum;
		logic [7:0]  window_accepted_sum;
		logic        probation_done;
		logic [1:0]  losing_windows;
		logic [15:0] promotions;
		logic [15:0] demotions;
	} state_t;

	// Result beat layout, lowest bits last in the list (packed MSB first).
	typedef struct packed {
		logic        pad;
		logic [1:0]  error;
		logic [15:0] demotion_count;
		logic [15:0] promotion_count;
		logic        is_monitoring;
		logic        is_probing;
		logic [2:0]  depth;
	} result_t;

	function automatic logic [7:0] sat8_add(input logic [7:0] a, input logic [3:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {5'd0, b};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	function automatic logic [15:0] sat16_inc(input logic [15:0] a);
		return (a == 16'hFFFF) ? a : a + 16'd1;
	endfunction

	function automatic logic [3:0] sat4_inc(input logic [3:0] a);
		return (a == 4'hF) ? a : a + 4'd1;
	endfunction

	function automatic logic [1:0] sat2_inc(input logic [1:0] a);
		return (a == 2'd3) ? a : a + 2'd1;
	endfunction

endpackage

// ===== hw/rtl/sdcu_cfg_regs.sv =====
`timescale 1ns / 1ps

module sdcu_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [19:0]         wr_data,
	output sdcu_pkg::cfg_t      cfg
);

	sdcu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_depth         <= sdcu_pkg::RST_MAX_DEPTH;
			cfg_q.prompt_length     <= sdcu_pkg::RST_PROMPT_LENGTH;
			cfg_q.demotion_on       <= sdcu_pkg::RST_DEMOTION_ON;
			cfg_q.early_demotion_on <= sdcu_pkg::RST_EARLY_DEM_ON;
		end else if (wr_en) begin
			unique case (sdcu_pkg::cfg_idx_t'(wr_index))
				sdcu_pkg::CFG_MAX_DEPTH:     cfg_q.max_depth         <= wr_data[2:0];
				sdcu_pkg::CFG_PROMPT_LENGTH: cfg_q.prompt_length     <= wr_data;
				sdcu_pkg::CFG_DEMOTION_ON:   cfg_q.demotion_on       <= wr_data[0];
				sdcu_pkg::CFG_EARLY_DEM_ON:  cfg_q.early_demotion_on <= wr_data[0];
				default:                     cfg_q                   <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/sdcu_step.sv =====
`timescale 1ns / 1ps

// Next-state logic for one start or observe beat.
module sdcu_step (
	input  sdcu_pkg::state_t cur,
	input  sdcu_pkg::cfg_t   cfg,
	input  logic             op,
	input  logic [3:0]       proposed,
	input  logic [3:0]       accepted,
	output sdcu_pkg::state_t nxt,
	output logic [1:0]       err
);

	always_comb begin
		logic [3:0] pcnt;
		logic [7:0] psum;
		logic [3:0] wcnt;
		logic [7:0] wp;
		logic [7:0] wa;
		logic       losing;
		logic [1:0] lw;

		nxt    = cur;
		err    = sdcu_pkg::ERR_OK;
		pcnt   = sdcu_pkg::sat4_inc(cur.probe_round_count);
		psum   = sdcu_pkg::sat8_add(cur.probe_accept_sum, accepted);
		wcnt   = sdcu_pkg::sat4_inc(cur.window_round_count);
		wp     = sdcu_pkg::sat8_add(cur.window_proposed_sum, proposed);
		wa     = sdcu_pkg::sat8_add(cur.window_accepted_sum, accepted);
		losing = ({wa, 1'b0} < {1'b0, wp});
		lw     = sdcu_pkg::sat2_inc(cur.losing_windows);

		priority if (op == sdcu_pkg::OP_START) begin
			if (cfg.max_depth == sdcu_pkg::DEPTH_BAD_ONE ||
			    cfg.max_depth > sdcu_pkg::DEPTH_MAX_OK) begin
				err = sdcu_pkg::ERR_BAD_DEPTH;
			end else begin
				nxt           = '0;
				nxt.cur_depth = cfg.max_depth;
				if (cfg.max_depth == sdcu_pkg::DEPTH_PROBED) begin
					nxt.cur_depth = sdcu_pkg::DEPTH_REDUCED;
					nxt.probing   = (cfg.prompt_length <= sdcu_pkg::PROMPT_SHORT_MAX);
				end
			end
		end else if (accepted > proposed) begin
			err = sdcu_pkg::ERR_ACC_GT_PROP;
		end else if (cur.cur_depth == sdcu_pkg::DEPTH_IDLE || proposed == 4'd0) begin
			nxt = cur;
		end else if (cur.probing) begin
			nxt.probe_round_count = pcnt;
			nxt.probe_accept_sum  = psum;
			if (pcnt == sdcu_pkg::PROBE_ROUNDS) begin
				nxt.probing = 1'b0;
				if (psum >= sdcu_pkg::PROBE_ACCEPT_NEEDED) begin
					nxt.cur_depth  = cfg.max_depth;
					nxt.monitoring = 1'b1;
					nxt.promotions = sdcu_pkg::sat16_inc(cur.promotions);
				end
			end
		end else if (cur.monitoring && cur.cur_depth == sdcu_pkg::DEPTH_PROBED &&
		             cfg.demotion_on) begin
			nxt.window_round_count  = wcnt;
			nxt.window_proposed_sum = wp;
			nxt.window_accepted_sum = wa;
			if (!cur.probation_done && cfg.early_demotion_on &&
			    wcnt == sdcu_pkg::PROBATION_ROUNDS && losing) begin
				// Early demotion leaves the window as it stands.
				nxt.cur_depth  = sdcu_pkg::DEPTH_REDUCED;
				nxt.monitoring = 1'b0;
				nxt.demotions  = sdcu_pkg::sat16_inc(cur.demotions);
			end else begin
				if (wcnt == sdcu_pkg::PROBATION_ROUNDS)
					nxt.probation_done = 1'b1;
				if (wcnt == sdcu_pkg::MONITOR_ROUNDS) begin
					if (losing) begin
						nxt.losing_windows = lw;
						if (lw == sdcu_pkg::LOSING_WINDOWS_TO_DEMOTE) begin
							nxt.cur_depth  = sdcu_pkg::DEPTH_REDUCED;
							nxt.monitoring = 1'b0;
							nxt.demotions  = sdcu_pkg::sat16_inc(cur.demotions);
						end
					end else begin
						nxt.losing_windows = 2'd0;
					end
					nxt.window_round_count  = 4'd0;
					nxt.window_proposed_sum = 8'd0;
					nxt.window_accepted_sum = 8'd0;
				end
			end
		end else begin
			nxt = cur;
		end
	end

endmodule

// ===== hw/rtl/speculation_depth_controller_unit.sv =====
`timescale 1ns / 1ps
// An accepted input beat passes through the input stage, then the result register on m_tvalid.
// Throughput: one beat per cycle while the result side keeps taking beats; the
// session state updates in a single pass of the step logic, so the next beat sees it in the following cycle.
// Reset (arst_n low, asynchronous): both stages empty, session state cleared,
// configuration back to max_depth 3, prompt_length 0, demotion on, early off.

module speculation_depth_controller_unit (
	input  logic        clk,
	input  logic        arst_n,

	// Input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] proposed, [7:4] accepted
	input  logic [0:0]  s_tuser,   // [0] op (0 start, 1 observe)

	// Result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [2:0] depth, [3] is_probing, [4] is_monitoring,
	                               // [20:5] promotion_count, [36:21] demotion_count,
	                               // [38:37] error, [39] zero

	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	sdcu_pkg::cfg_t    cfg;
	sdcu_pkg::state_t  state_q;
	sdcu_pkg::state_t  state_nxt;
	sdcu_pkg::result_t out_q;
	logic [1:0]        step_err;

	logic       valid_s1;
	logic       op_s1;
	logic [3:0] proposed_s1;
	logic [3:0] accepted_s1;
	logic       out_valid_q;
	logic       advance;
	logic       s_accept;

	// Configuration is never back-pressured.
	assign cfg_ready = 1'b1;

	sdcu_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move the held beat into the result register when that slot is free or
	// drains this cycle; the input stage refills in the same cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input stage; hold while stalled.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_s1       <= s_tuser[0];
			proposed_s1 <= s_tdata[3:0];
			accepted_s1 <= s_tdata[7:4];
		end
	end

	sdcu_step u_step (
		.cur      (state_q),
		.cfg      (cfg),
		.op       (op_s1),
		.proposed (proposed_s1),
		.accepted (accepted_s1),
		.nxt      (state_nxt),
		.err      (step_err)
	);

	// Session state commits exactly when its beat leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.pad             <= 1'b0;
			out_q.error           <= step_err;
			out_q.demotion_count  <= state_nxt.demotions;
			out_q.promotion_count <= state_nxt.promotions;
			out_q.is_monitoring   <= state_nxt.monitoring;
			out_q.is_probing      <= state_nxt.probing;
			out_q.depth           <= state_nxt.cur_depth;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

// ===== hw/rtl/sdcu_checker.sv =====
`timescale 1ns / 1ps
`include "speculation_depth_controller_unit_macros.svh"

module sdcu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	`SDCU_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")
	`SDCU_ASSERT_CLK(a_err_code, m_tvalid |-> m_tdata[38:37] <= sdcu_pkg::ERR_BAD_DEPTH, "undefined error code")
	`SDCU_ASSERT_CLK(a_probe_depth, m_tvalid && m_tdata[3] |-> m_tdata[2:0] == sdcu_pkg::DEPTH_REDUCED, "probing off depth 2")
	`SDCU_ASSERT_CLK(a_phase_excl, m_tvalid |-> !(m_tdata[3] && m_tdata[4]), "probing and monitoring at once")
	`SDCU_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_tvalid, "result beat during reset")

endmodule

bind speculation_depth_controller_unit sdcu_checker u_sdcu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

// ===== dv/depth_result_checker.sv =====
`timescale 1ns / 1ps

module depth_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	output int          pending,
	output int          fail_count
);

	typedef struct packed {
		logic [2:0]  depth;
		logic        probing;
		logic        monitoring;
		logic [3:0]  probe_rounds;
		logic [7:0]  probe_accepts;
		logic [3:0]  window_rounds;
		logic [7:0]  window_proposed;
		logic [7:0]  window_accepted;
		logic        probation_over;
		logic [1:0]  losing_run;
		logic [15:0] promotions;
		logic [15:0] demotions;
	} session_t;

	sdcu_pkg::cfg_t    regs;
	session_t          sess;
	sdcu_pkg::result_t due_results[$];
	int                fails = 0;

	function automatic logic [7:0] add_capped(input logic [7:0] sum, input logic [3:0] tokens);
		int total;
		total = int'(sum) + int'(tokens);
		return (total > 255) ? 8'd255 : 8'(total);
	endfunction

	function automatic logic [15:0] bump(input logic [15:0] count);
		return (count == 16'hFFFF) ? count : count + 16'd1;
	endfunction

	// Fewer than half of the window's proposals were accepted.
	function automatic bit window_losing();
		return 2 * int'(sess.window_accepted) < int'(sess.window_proposed);
	endfunction

	function automatic void fall_back();
		sess.depth = sdcu_pkg::DEPTH_REDUCED;
		sess.monitoring = 1'b0;
		sess.demotions = bump(sess.demotions);
	endfunction

	function automatic sdcu_pkg::result_t advance_session(input sdcu_pkg::op_t op,
			input logic [3:0] prop, input logic [3:0] acc);
		sdcu_pkg::result_t res;
		sdcu_pkg::err_t    err;
		err = sdcu_pkg::ERR_OK;
		if (op == sdcu_pkg::OP_START) begin
			if (regs.max_depth == sdcu_pkg::DEPTH_BAD_ONE ||
					regs.max_depth > sdcu_pkg::DEPTH_MAX_OK) begin
				err = sdcu_pkg::ERR_BAD_DEPTH;
			end else begin
				sess = '0;
				sess.depth = regs.max_depth;
				if (regs.max_depth == sdcu_pkg::DEPTH_PROBED) begin
					sess.depth = sdcu_pkg::DEPTH_REDUCED;
					sess.probing = (regs.prompt_length <= sdcu_pkg::PROMPT_SHORT_MAX);
				end
			end
		end else if (acc > prop) begin
			err = sdcu_pkg::ERR_ACC_GT_PROP;
		end else if (sess.depth != sdcu_pkg::DEPTH_IDLE && prop != 4'd0) begin
			if (sess.probing) begin
				if (sess.probe_rounds != 4'hF)
					sess.probe_rounds = sess.probe_rounds + 4'd1;
				sess.probe_accepts = add_capped(sess.probe_accepts, acc);
				if (sess.probe_rounds == sdcu_pkg::PROBE_ROUNDS) begin
					sess.probing = 1'b0;
					if (sess.probe_accepts >= sdcu_pkg::PROBE_ACCEPT_NEEDED) begin
						sess.depth = regs.max_depth;
						sess.monitoring = 1'b1;
						sess.promotions = bump(sess.promotions);
					end
				end
			end else if (sess.monitoring && sess.depth == sdcu_pkg::DEPTH_PROBED &&
					regs.demotion_on) begin
				if (sess.window_rounds != 4'hF)
					sess.window_rounds = sess.window_rounds + 4'd1;
				sess.window_proposed = add_capped(sess.window_proposed, prop);
				sess.window_accepted = add_capped(sess.window_accepted, acc);
				if (!sess.probation_over && regs.early_demotion_on &&
						sess.window_rounds == sdcu_pkg::PROBATION_ROUNDS &&
						window_losing()) begin
					fall_back();
				end else begin
					if (sess.window_rounds == sdcu_pkg::PROBATION_ROUNDS)
						sess.probation_over = 1'b1;
					if (sess.window_rounds == sdcu_pkg::MONITOR_ROUNDS) begin
						if (window_losing()) begin
							if (sess.losing_run != 2'd3)
								sess.losing_run = sess.losing_run + 2'd1;
							if (sess.losing_run == sdcu_pkg::LOSING_WINDOWS_TO_DEMOTE)
								fall_back();
						end else begin
							sess.losing_run = 2'd0;
						end
						sess.window_rounds = '0;
						sess.window_proposed = '0;
						sess.window_accepted = '0;
					end
				end
			end
		end
		res = '0;
		res.depth = sess.depth;
		res.is_probing = sess.probing;
		res.is_monitoring = sess.monitoring;
		res.promotion_count = sess.promotions;
		res.demotion_count = sess.demotions;
		res.error = err;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		sdcu_pkg::result_t want;
		sdcu_pkg::result_t got;
		if (!arst_n) begin
			regs.max_depth = sdcu_pkg::RST_MAX_DEPTH;
			regs.prompt_length = sdcu_pkg::RST_PROMPT_LENGTH;
			regs.demotion_on = sdcu_pkg::RST_DEMOTION_ON;
			regs.early_demotion_on = sdcu_pkg::RST_EARLY_DEM_ON;
			sess = '0;
			due_results.delete();
			pending <= 0;
			fail_count <= fails;
		end else begin
			// Retire the oldest expectation before queuing a new one.
			if (m_tvalid && m_tready) begin
				got = sdcu_pkg::result_t'(m_tdata);
				if (due_results.size() == 0) begin
					$error("result beat %h arrived with nothing expected", m_tdata);
					fails++;
				end else begin
					want = due_results.pop_front();
					check_field("depth", want.depth, got.depth);
					check_field("is_probing", want.is_probing, got.is_probing);
					check_field("is_monitoring", want.is_monitoring, got.is_monitoring);
					check_field("promotion_count", want.promotion_count, got.promotion_count);
					check_field("demotion_count", want.demotion_count, got.demotion_count);
					check_field("error", want.error, got.error);
					check_field("pad", want.pad, got.pad);
				end
			end
			if (s_tvalid && s_tready)
				due_results.push_back(advance_session(sdcu_pkg::op_t'(s_tuser[0]),
					s_tdata[3:0], s_tdata[7:4]));
			if (cfg_valid && cfg_ready) begin
				case (sdcu_pkg::cfg_idx_t'(cfg_index))
					sdcu_pkg::CFG_MAX_DEPTH:     regs.max_depth = cfg_data[2:0];
					sdcu_pkg::CFG_PROMPT_LENGTH: regs.prompt_length = cfg_data;
					sdcu_pkg::CFG_DEMOTION_ON:   regs.demotion_on = cfg_data[0];
					sdcu_pkg::CFG_EARLY_DEM_ON:  regs.early_demotion_on = cfg_data[0];
					default: ;
				endcase
			end
			pending <= due_results.size();
			fail_count <= fails;
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int ITEM_TARGET   = 600;
	// Receiver hold-off long enough to back up both stages and stall the input.
	localparam int PRESSURE_HOLD = 300;
	// Cycles without any beat before the run is declared hung.
	localparam int IDLE_LIMIT    = 3000;
	// Quiet cycles after the last result.
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [3:0] proposed, [7:4] accepted
	logic [0:0]  s_tuser;    // [0] op
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;    // [2:0] depth, [3] is_probing, [4] is_monitoring,
	                         // [20:5] promotion_count, [36:21] demotion_count,
	                         // [38:37] error, [39] zero
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [19:0] cfg_data;

	int pending;
	int fail_count;
	int sent = 0;
	int idle_cycles = 0;
	bit eager = 1'b0;

	always #10 clk = ~clk;

	speculation_depth_controller_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	depth_result_checker depth_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// Mostly back to back, often a short gap, now and then a long pause.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Offer one beat and hold it until the block takes it. Leave tvalid high on
	// return so a back-to-back beat never drops and re-raises it in one step.
	task automatic send_beat(input sdcu_pkg::op_t op, input logic [3:0] prop,
			input logic [3:0] acc);
		int gap;
		gap = eager ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {acc, prop};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	// Drop tvalid and wait until every expected result beat has been taken.
	// Each beat produces exactly one result, so the block is idle afterwards.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input sdcu_pkg::cfg_idx_t idx, input logic [19:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Write the whole register set while the block is idle.
	task automatic load_config(input logic [2:0] depth, input logic [19:0] prompt,
			input logic demote_en, input logic early_en);
		drain();
		write_reg(sdcu_pkg::CFG_MAX_DEPTH, {17'd0, depth});
		write_reg(sdcu_pkg::CFG_PROMPT_LENGTH, prompt);
		write_reg(sdcu_pkg::CFG_DEMOTION_ON, {19'd0, demote_en});
		write_reg(sdcu_pkg::CFG_EARLY_DEM_ON, {19'd0, early_en});
		cfg_valid <= 1'b0;
	endtask

	// One stretch of rounds. Well-formed rounds dominate so sessions get through
	// probing into monitoring; early rounds lean strong to earn the promotion,
	// later rounds lean low per weak_pct to drive losing windows and demotion.
	task automatic run_session(input int rounds, input bit opening, input int weak_pct);
		int         pick;
		bit         lean_low;
		logic [3:0] prop;
		logic [3:0] acc;
		if (opening)
			send_beat(sdcu_pkg::OP_START, 4'($urandom), 4'($urandom));
		for (int k = 0; k < rounds; k++) begin
			pick = $urandom_range(99);
			if (pick < 3) begin
				// accepted above proposed
				prop = 4'($urandom_range(14));
				acc  = 4'($urandom_range(15, prop + 1));
				send_beat(sdcu_pkg::OP_OBSERVE, prop, acc);
			end else if (pick < 6) begin
				send_beat(sdcu_pkg::OP_OBSERVE, 4'd0, 4'd0);
			end else if (pick < 8) begin
				send_beat(sdcu_pkg::OP_START, 4'($urandom), 4'($urandom));
			end else begin
				prop = 4'($urandom_range(15, 1));
				if (k <= int'(sdcu_pkg::PROBE_ROUNDS))
					lean_low = ($urandom_range(99) < 15);
				else
					lean_low = ($urandom_range(99) < weak_pct);
				if (lean_low)
					acc = 4'($urandom_range((prop - 1) / 2));
				else
					acc = 4'($urandom_range(prop, prop / 2 + 1));
				send_beat(sdcu_pkg::OP_OBSERVE, prop, acc);
			end
		end
	endtask

	// Hang detector: count cycles with no beat on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: random stalls, calm stretches, and two long hold-offs
	// so the pipeline fills and pushes back on the input.
	initial begin : result_sink
		int taken;
		int hold;
		int gap;
		bit smooth;
		taken = 0;
		hold = 0;
		smooth = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				taken++;
				if (taken % 64 == 0)
					smooth = ($urandom_range(3) == 0);
				if (taken == 150 || taken == 400)
					hold = PRESSURE_HOLD;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (smooth) begin
				m_tready <= 1'b1;
			end else begin
				gap = pick_gap();
				m_tready <= (gap == 0);
				hold = (gap > 0) ? gap - 1 : 0;
			end
		end
	end

	initial begin : stimulus
		int          step;
		int          roll;
		int          weak_pct;
		logic [2:0]  depth;
		logic [19:0] prompt;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= sdcu_pkg::OP_START;
		cfg_valid <= 1'b0;
		cfg_index <= sdcu_pkg::CFG_MAX_DEPTH;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset configuration gives max depth 3 with a short prompt.
		eager = 1'b1;
		send_beat(sdcu_pkg::OP_OBSERVE, 4'd5, 4'd3);     // no session open yet, depth stays 0
		send_beat(sdcu_pkg::OP_OBSERVE, 4'd0, 4'd15);    // accepted above proposed
		send_beat(sdcu_pkg::OP_START, 4'd0, 4'd0);       // depth 2, probing
		send_beat(sdcu_pkg::OP_OBSERVE, 4'd0, 4'd0);     // nothing proposed, no round
		send_beat(sdcu_pkg::OP_OBSERVE, 4'd14, 4'd15);   // flagged, probe count untouched
		repeat (int'(sdcu_pkg::PROBE_ROUNDS)) send_beat(sdcu_pkg::OP_OBSERVE, 4'd15, 4'd15);
		send_beat(sdcu_pkg::OP_OBSERVE, 4'd15, 4'd0);    // first monitored round at depth 3

		// Bad maximum depth: start is flagged, open session carries on.
		load_config(sdcu_pkg::DEPTH_BAD_ONE, 20'd0, 1'b1, 1'b0);
		send_beat(sdcu_pkg::OP_START, 4'd0, 4'd0);
		send_beat(sdcu_pkg::OP_OBSERVE, 4'd15, 4'd15);
		// Depth 4 straight away, longest prompt.
		load_config(sdcu_pkg::DEPTH_MAX_OK, 20'hFFFFF, 1'b0, 1'b1);
		send_beat(sdcu_pkg::OP_START, 4'd0, 4'd0);
		send_beat(sdcu_pkg::OP_OBSERVE, 4'd9, 4'd9);
		// Depth 0 session: every round is idle.
		load_config(sdcu_pkg::DEPTH_IDLE, sdcu_pkg::PROMPT_SHORT_MAX, 1'b1, 1'b1);
		send_beat(sdcu_pkg::OP_START, 4'd0, 4'd0);
		send_beat(sdcu_pkg::OP_OBSERVE, 4'd7, 4'd2);
		// Prompt exactly at the short limit still probes.
		load_config(sdcu_pkg::DEPTH_PROBED, sdcu_pkg::PROMPT_SHORT_MAX, 1'b1, 1'b1);
		send_beat(sdcu_pkg::OP_START, 4'd0, 4'd0);
		// One token past the limit: depth 2 without probing.
		load_config(sdcu_pkg::DEPTH_PROBED, sdcu_pkg::PROMPT_SHORT_MAX + 20'd1, 1'b0, 1'b0);
		send_beat(sdcu_pkg::OP_START, 4'd0, 4'd0);
		send_beat(sdcu_pkg::OP_OBSERVE, 4'd8, 4'd1);

		// Random sessions. Some phases keep the open session, some change the
		// registers under it, most reconfigure and start over.
		eager = 1'b0;
		while (sent < ITEM_TARGET) begin
			step = $urandom_range(99);
			if (step >= 15) begin
				roll = $urandom_range(9);
				depth = (roll < 6) ? sdcu_pkg::DEPTH_PROBED : 3'($urandom_range(4));
				roll = $urandom_range(9);
				case (roll)
					6:       prompt = sdcu_pkg::PROMPT_SHORT_MAX;
					7:       prompt = sdcu_pkg::PROMPT_SHORT_MAX + 20'd1;
					8:       prompt = 20'hFFFFF;
					9:       prompt = 20'($urandom_range(20'hFFFFF, 2049));
					default: prompt = 20'($urandom_range(2048));
				endcase
				load_config(depth, prompt, 1'($urandom_range(9) != 0), 1'($urandom_range(1)));
			end
			case ($urandom_range(3))
				0:       weak_pct = 0;
				1:       weak_pct = 30;
				2:       weak_pct = 80;
				default: weak_pct = 100;
			endcase
			eager = ($urandom_range(4) == 0);
			run_session($urandom_range(60, 10), step >= 30, weak_pct);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
